FILE: rtl/pfrgb_pkg.sv
// ----------------------------------------------------------------------------
// pfrgb_pkg
// Shared types, register indexes and constants of the pixel format converter.
// ----------------------------------------------------------------------------
package pfrgb_pkg;

	localparam int DEF_MAX_LINE_WIDTH   = 4096;
	localparam int DEF_MAX_FRAME_HEIGHT = 4096;

	localparam int MODE_W = 3;
	localparam int DIM_W  = 13;
	localparam int IDX_W  = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_YUYV   = 3'd0,
		MODE_YVYU   = 3'd1,
		MODE_UYVY   = 3'd2,
		MODE_RGB565 = 3'd3,
		MODE_BGR24  = 3'd4,
		MODE_YCBCR  = 3'd5
	} pixel_mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PIXEL_MODE   = 2'd0,
		REG_LINE_WIDTH   = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} reg_index_t;

	localparam logic [DIM_W-1:0] RST_LINE_WIDTH   = 13'd640;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	// BT.601 integer coefficients (scaled by 256)
	localparam int COEF_Y   = 298;
	localparam int COEF_RV  = 409;
	localparam int COEF_GU  = 100;
	localparam int COEF_GV  = 208;
	localparam int COEF_BU  = 516;
	localparam int ROUND    = 128;
	localparam int Y_OFFSET = 16;
	localparam int C_OFFSET = 128;

	// RGB565 field masks
	localparam logic [7:0]  MASK_R5 = 8'd248;
	localparam logic [15:0] MASK_G6 = 16'd2016;
	localparam logic [7:0]  MASK_B5 = 8'd31;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} pixel_t;

	typedef struct packed {
		logic known;   // mode is one of the defined formats
		logic pair;    // word carries two pixels sharing chroma
	} conv_info_t;

	// Last index of a line or frame: zero counts as one, large values saturate.
	function automatic int unsigned dim_last(input logic [DIM_W-1:0] v,
			input int unsigned max_dim);
		int unsigned eff;
		eff = 32'(v);
		if (eff == 0) begin
			eff = 1;
		end else if (eff > max_dim) begin
			eff = max_dim;
		end
		return eff - 1;
	endfunction

endpackage

FILE: rtl/pfrgb_pixel_calc.sv
// ----------------------------------------------------------------------------
// pfrgb_pixel_calc
// Converts one held input word into the components of one output pixel.
// ----------------------------------------------------------------------------
module pfrgb_pixel_calc import pfrgb_pkg::*; (
	input  logic [MODE_W-1:0] mode,
	input  logic [31:0]       word,
	input  logic              second,
	output pixel_t            pix,
	output conv_info_t        info
);

	logic [7:0] b0, b1, b2, b3;
	logic [15:0] w565;
	logic signed [9:0] yc, cb, cr;
	logic signed [19:0] sum_r, sum_g, sum_b;

	assign b0 = word[7:0];
	assign b1 = word[15:8];
	assign b2 = word[23:16];
	assign b3 = word[31:24];
	assign w565 = {b1, b0};

	function automatic logic [7:0] clip8(input logic signed [19:0] s);
		logic [11:0] q;
		q = s[19:8];
		if (s[19]) begin
			return 8'd0;
		end else if (q > 12'd255) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

	always_comb begin
		yc = $signed({2'b00, b0}) - 10'(Y_OFFSET);
		cb = $signed({2'b00, b1}) - 10'(C_OFFSET);
		cr = $signed({2'b00, b2}) - 10'(C_OFFSET);
		sum_r = 20'(COEF_Y * yc + COEF_RV * cr + ROUND);
		sum_g = 20'(COEF_Y * yc - COEF_GU * cb - COEF_GV * cr + ROUND);
		sum_b = 20'(COEF_Y * yc + COEF_BU * cb + ROUND);
	end

	always_comb begin
		pix  = '0;
		info = '{known: 1'b1, pair: 1'b0};
		unique case (mode)
			MODE_YUYV: begin
				pix = '{c0: second ? b2 : b0, c1: b1, c2: b3};
				info.pair = 1'b1;
			end
			MODE_YVYU: begin
				pix = '{c0: second ? b2 : b0, c1: b3, c2: b1};
				info.pair = 1'b1;
			end
			MODE_UYVY: begin
				pix = '{c0: second ? b3 : b1, c1: b0, c2: b2};
				info.pair = 1'b1;
			end
			MODE_RGB565: begin
				pix.c0 = b1 & MASK_R5;
				pix.c1 = 8'((w565 & MASK_G6) >> 3);
				pix.c2 = 8'((b0 & MASK_B5) << 3);
			end
			MODE_BGR24: begin
				pix = '{c0: b2, c1: b1, c2: b0};
			end
			MODE_YCBCR: begin
				pix = '{c0: clip8(sum_r), c1: clip8(sum_g), c2: clip8(sum_b)};
			end
			default: begin
				info.known = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/pixel_format_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_to_rgb_converter
// Streaming pixel converter with line and frame end marking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one 32-bit word per item. Output
//   channel out_valid/out_ready carries one pixel per item with line_end,
//   frame_end and last. The cfg channel writes pixel_mode, line_width and
//   frame_height by index; cfg_ready is always high, indexes past the list
//   are ignored. Write configuration only while the stream is idle.
//   An accepted word sits in an input register; the conversion logic feeds an
//   output register. Single-pixel formats sustain one word per cycle while
//   out_ready is high. Packed 4:2:2 words give two pixels through the one
//   output register, so the input register holds the word until its second
//   pixel is issued (a pair cut short at line end gives one pixel only).
//   Undefined modes drop the word without output and without moving the
//   counters. When out_ready is low the output register holds and the input
//   register fills; in_ready then drops. Reset empties both registers, zeroes
//   the column and row counters and loads the defaults (YUYV, 640 x 480).
// ----------------------------------------------------------------------------
module pixel_format_to_rgb_converter import pfrgb_pkg::*; #(
	parameter int MAX_LINE_WIDTH   = DEF_MAX_LINE_WIDTH,
	parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       pixel_bytes,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        comp0,
	output logic [7:0]        comp1,
	output logic [7:0]        comp2,
	output logic              line_end,
	output logic              frame_end,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam int RW = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;

	logic [MODE_W-1:0] mode_q;
	logic [DIM_W-1:0]  width_q, height_q;
	logic [CW-1:0]     col_q, col_last;
	logic [RW-1:0]     row_q, row_last;

	logic [31:0] word_s1;
	logic        valid_s1, second_s1;

	pixel_t     pix;
	conv_info_t info;

	logic emit_ok, single, two, fire, done, le, fe;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_YUYV;
			width_q  <= RST_LINE_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PIXEL_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_LINE_WIDTH:   width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign col_last = CW'(dim_last(width_q, MAX_LINE_WIDTH));
	assign row_last = RW'(dim_last(height_q, MAX_FRAME_HEIGHT));

	pfrgb_pixel_calc u_calc (
		.mode   (mode_q),
		.word   (word_s1),
		.second (second_s1),
		.pix    (pix),
		.info   (info)
	);

	assign le      = col_q >= col_last;
	assign fe      = le && (row_q >= row_last);
	assign single  = le;
	assign emit_ok = !out_valid || out_ready;
	assign two     = info.pair && !second_s1 && !single;
	assign fire    = valid_s1 && info.known && emit_ok;
	assign done    = valid_s1 && (!info.known || (emit_ok && !two));
	assign in_ready = !valid_s1 || done;

	// input register: hold the word until its final pixel is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			second_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1  <= 1'b1;
			second_s1 <= 1'b0;
		end else if (done) begin
			valid_s1  <= 1'b0;
		end else if (fire && two) begin
			second_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= pixel_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			if (le) begin
				col_q <= '0;
				row_q <= fe ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			comp0     <= pix.c0;
			comp1     <= pix.c1;
			comp2     <= pix.c2;
			line_end  <= le;
			frame_end <= fe;
			last      <= !two;
		end
	end

endmodule

FILE: rtl/pfrgb_checker.sv
// ----------------------------------------------------------------------------
// pfrgb_checker
// Port-level checks of the pixel format converter, bound to the top level.
// ----------------------------------------------------------------------------
module pfrgb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] comp0,
	input logic [7:0] comp1,
	input logic [7:0] comp2,
	input logic       line_end,
	input logic       frame_end,
	input logic       last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(comp0) && $stable(comp1)
			&& $stable(comp2) && $stable(line_end) && $stable(frame_end) && $stable(last))
		else $error("stalled result changed");

	a_frame_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || line_end))
		else $error("frame end without line end");

	// the first pixel of a pair never closes a line
	a_pair_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !line_end)
		else $error("line end on first pixel of a pair");

	// the second pixel of a pair follows at once
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second pixel of a pair missing");

endmodule

bind pixel_format_to_rgb_converter pfrgb_checker u_pfrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.comp0     (comp0),
	.comp1     (comp1),
	.comp2     (comp2),
	.line_end  (line_end),
	.frame_end (frame_end),
	.last      (last)
);

FILE: bench/tb_pixel_format_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// tb_pixel_format_to_rgb_converter
// Self-checking bench for the pixel format converter. Every accepted word is
// run through a behavioral predictor of the conversion and of the line and
// frame counters. Each output pixel is compared against the oldest expected
// pixel. Directed words cover the format corners, then random phases mix
// modes, line widths and frame heights under random input gaps and output
// stalls.
// ----------------------------------------------------------------------------
module tb_pixel_format_to_rgb_converter;
	timeunit 1ns;
	timeprecision 1ps;

	import pfrgb_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNDEF_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNDEF_7 = 3'd7;
	localparam logic [IDX_W-1:0]  REG_UNUSED   = 2'd3;
	localparam int RANDOM_WORDS = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       line_end;
		logic       frame_end;
		logic       last_of_word;
	} pixel_rec_t;

	// Predicts output pixels per accepted word and checks them in order.
	class pixel_scoreboard;
		logic [MODE_W-1:0] mode;
		logic [DIM_W-1:0]  width_reg;
		logic [DIM_W-1:0]  height_reg;
		int unsigned       column;
		int unsigned       row;
		pixel_rec_t        expected_pixels[$];
		int unsigned       mismatches;

		function new();
			mode       = MODE_YUYV;
			width_reg  = RST_LINE_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			column     = 0;
			row        = 0;
			mismatches = 0;
		endfunction

		function void write_register(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
			case (idx)
				REG_PIXEL_MODE:   mode = data[MODE_W-1:0];
				REG_LINE_WIDTH:   width_reg = data;
				REG_FRAME_HEIGHT: height_reg = data;
				default: ;
			endcase
		endfunction

		function int unsigned span_end(logic [DIM_W-1:0] v, int unsigned max_dim);
			int unsigned eff;
			eff = v;
			if (eff == 0)
				eff = 1;
			else if (eff > max_dim)
				eff = max_dim;
			return eff - 1;
		endfunction

		function logic [7:0] to_byte(int sum);
			if (sum < 0)
				return 8'd0;
			sum = sum / 256;
			if (sum > 255)
				return 8'd255;
			return sum[7:0];
		endfunction

		function void push_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic is_last);
			pixel_rec_t p;
			logic le, fe;
			le = column >= span_end(width_reg, DEF_MAX_LINE_WIDTH);
			fe = le && row >= span_end(height_reg, DEF_MAX_FRAME_HEIGHT);
			p = '{a, b, c, le, fe, is_last};
			expected_pixels.push_back(p);
			if (le) begin
				column = 0;
				row = fe ? 0 : row + 1;
			end else begin
				column++;
			end
		endfunction

		function void note_word(logic [31:0] word);
			logic [7:0] b0, b1, b2, b3, y0, y1, cu, cv;
			logic [15:0] w565;
			int cy, cb, cr;
			b0 = word[7:0];
			b1 = word[15:8];
			b2 = word[23:16];
			b3 = word[31:24];
			case (mode)
				MODE_YUYV, MODE_YVYU, MODE_UYVY: begin
					if (mode == MODE_YUYV) begin
						y0 = b0; y1 = b2; cu = b1; cv = b3;
					end else if (mode == MODE_YVYU) begin
						y0 = b0; y1 = b2; cu = b3; cv = b1;
					end else begin
						y0 = b1; y1 = b3; cu = b0; cv = b2;
					end
					// drop the second pixel when the first one closes the line
					if (column >= span_end(width_reg, DEF_MAX_LINE_WIDTH)) begin
						push_pixel(y0, cu, cv, 1'b1);
					end else begin
						push_pixel(y0, cu, cv, 1'b0);
						push_pixel(y1, cu, cv, 1'b1);
					end
				end
				MODE_RGB565: begin
					w565 = {b1, b0};
					push_pixel(b1 & MASK_R5, 8'((w565 & MASK_G6) >> 3),
						8'((b0 & MASK_B5) << 3), 1'b1);
				end
				MODE_BGR24: push_pixel(b2, b1, b0, 1'b1);
				MODE_YCBCR: begin
					cy = int'(b0) - Y_OFFSET;
					cb = int'(b1) - C_OFFSET;
					cr = int'(b2) - C_OFFSET;
					push_pixel(to_byte(COEF_Y * cy + COEF_RV * cr + ROUND),
						to_byte(COEF_Y * cy - COEF_GU * cb - COEF_GV * cr + ROUND),
						to_byte(COEF_Y * cy + COEF_BU * cb + ROUND), 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void check_pixel(pixel_rec_t got);
			pixel_rec_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel with nothing expected: comp0 %0d comp1 %0d comp2 %0d",
					got.c0, got.c1, got.c2);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.c0 !== want.c0) begin
				$error("comp0: expected %0d, actual %0d", want.c0, got.c0);
				mismatches++;
			end
			if (got.c1 !== want.c1) begin
				$error("comp1: expected %0d, actual %0d", want.c1, got.c1);
				mismatches++;
			end
			if (got.c2 !== want.c2) begin
				$error("comp2: expected %0d, actual %0d", want.c2, got.c2);
				mismatches++;
			end
			if (got.line_end !== want.line_end) begin
				$error("line_end: expected %0b, actual %0b", want.line_end, got.line_end);
				mismatches++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
				mismatches++;
			end
			if (got.last_of_word !== want.last_of_word) begin
				$error("last: expected %0b, actual %0b", want.last_of_word, got.last_of_word);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [31:0]       pixel_bytes = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [7:0]        comp0, comp1, comp2;
	logic              line_end, frame_end, last;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index   = '0;
	logic [DIM_W-1:0]  cfg_data    = '0;

	pixel_scoreboard sb = new();
	bit          hold_req  = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned burst_left = 0;
	int unsigned random_items = 0;

	pixel_format_to_rgb_converter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_bytes(pixel_bytes),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.comp0      (comp0),
		.comp1      (comp1),
		.comp2      (comp2),
		.line_end   (line_end),
		.frame_end  (frame_end),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Output side: check accepted pixels, then pick the next ready value.
	initial begin
		int unsigned hold_left;
		int unsigned style;
		int unsigned style_left;
		logic        ready_next;
		hold_left = 0;
		style = 0;
		style_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_pixel('{comp0, comp1, comp2, line_end, frame_end, last});
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (style_left == 0) begin
				style = $urandom_range(0, 3);
				style_left = $urandom_range(16, 200);
			end
			style_left--;
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				case (style)
					0: ready_next = 1'b1;
					1: ready_next = $urandom_range(0, 1);
					2: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = ~out_ready;
				endcase
			end
			out_ready <= ready_next;
		end
	end

	task automatic send_word(logic [31:0] word);
		in_valid <= 1'b1;
		pixel_bytes <= word;
		do @(posedge clk); while (!in_ready);
		sb.note_word(word);
	endtask

	// Drain every expected pixel, then let dropped words leave the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
	endtask

	task automatic configure(logic [MODE_W-1:0] mode, logic [DIM_W-1:0] width,
			logic [DIM_W-1:0] height);
		settle();
		write_reg(REG_PIXEL_MODE, {10'($urandom), mode});
		write_reg(REG_LINE_WIDTH, width);
		write_reg(REG_FRAME_HEIGHT, height);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_one(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		settle();
		write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random(int unsigned count);
		int unsigned gap;
		int unsigned r;
		for (int unsigned i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				r = $urandom_range(0, 9);
				gap = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 30);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			// stall the output for a long stretch while words keep coming
			if (!hold_done && random_items >= 300 && sb.mode <= MODE_YCBCR) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			send_word($urandom);
			burst_left--;
			if (sb.mode <= MODE_YCBCR)
				random_items++;
		end
	endtask

	function automatic logic [MODE_W-1:0] pick_mode();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 14)
			return MODE_UNDEF_6;
		if (r == 15)
			return MODE_UNDEF_7;
		return MODE_W'(r % 6);
	endfunction

	function automatic logic [DIM_W-1:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return DIM_W'($urandom_range(1, 9));
		if (r < 15)
			return DIM_W'($urandom_range(10, 64));
		case (r)
			15: return DIM_W'(0);
			16: return DIM_W'(DEF_MAX_LINE_WIDTH);
			17: return DIM_W'(DEF_MAX_LINE_WIDTH + 1);
			18: return '1;
			default: return DIM_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_height();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 13)
			return DIM_W'($urandom_range(1, 4));
		case (r)
			13: return DIM_W'(0);
			14: return DIM_W'(1);
			15: return DIM_W'(DEF_MAX_FRAME_HEIGHT);
			16: return '1;
			default: return DIM_W'($urandom_range(5, 40));
		endcase
	endfunction

	initial begin
		logic [MODE_W-1:0] phase_mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset configuration
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);

		// odd width: the second word holds a pair cut short at the line end
		configure(MODE_YUYV, 13'd3, 13'd2);
		send_word(32'h1122_3344);
		send_word(32'hA5A5_A5A5);
		send_word(32'h5A5A_5A5A);
		configure(MODE_YVYU, 13'd4, 13'd2);
		send_word(32'h80FF_0001);
		configure(MODE_UYVY, 13'd4, 13'd2);
		send_word(32'h01FF_80FE);

		configure(MODE_RGB565, 13'd2, 13'd2);
		send_word(32'h0000_FFFF);
		send_word(32'hFFFF_F800);
		send_word(32'h0000_07E0);
		send_word(32'h0000_001F);

		configure(MODE_BGR24, 13'd5, 13'd3);
		send_word(32'hFF12_3456);

		// black, white, saturation high and low
		configure(MODE_YCBCR, 13'd3, 13'd2);
		send_word(32'h0080_8010);
		send_word(32'h0080_80EB);
		send_word(32'h00FF_00FF);
		send_word(32'h0000_FF00);
		send_word(32'hFFFF_FFFF);

		// undefined modes drop the word
		configure(MODE_UNDEF_6, 13'd4, 13'd4);
		send_word($urandom);
		write_one(REG_PIXEL_MODE, {10'($urandom), MODE_UNDEF_7});
		send_word($urandom);
		write_one(REG_UNUSED, DIM_W'($urandom));

		// zero sizes count as one
		configure(MODE_BGR24, 13'd0, 13'd0);
		send_word(32'h00FF_8001);

		// shrink the sizes under counters already past the new end
		configure(MODE_BGR24, 13'd8, 13'd8);
		send_random(12);
		write_one(REG_LINE_WIDTH, 13'd2);
		write_one(REG_FRAME_HEIGHT, 13'd1);
		send_word($urandom);

		random_items = 0;
		while (random_items < RANDOM_WORDS) begin
			phase_mode = pick_mode();
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0: write_one(REG_PIXEL_MODE, {10'($urandom), phase_mode});
					1: write_one(REG_LINE_WIDTH, pick_width());
					default: write_one(REG_FRAME_HEIGHT, pick_height());
				endcase
			end else begin
				configure(phase_mode, pick_width(), pick_height());
			end
			send_random($urandom_range(1, 80));
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pfrgb_pkg.sv
rtl/pfrgb_pixel_calc.sv
rtl/pixel_format_to_rgb_converter.sv
rtl/pfrgb_checker.sv
bench/tb_pixel_format_to_rgb_converter.sv
